FILE: rtl/core/esd_pkg.sv
package esd_pkg;

    typedef enum logic [1:0]
    {
        MODE_NORMAL,
        MODE_ESC,
        MODE_OCT1,
        MODE_OCT2
    } esd_mode_t;

    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_QUOTE     = 8'h27;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_A         = 8'h61;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6e;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_V         = 8'h76;
    localparam logic [9:0] VALUE_LIMIT  = 10'd256;

    // one queue entry: the results caused by one input beat
    typedef struct packed {
        logic [7:0] byte0;
        logic       pres0;
        logic [7:0] byte1;
        logic       two;
        logic       last;
    } esd_entry_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] value;
    } esd_map_t;

    function automatic esd_map_t simple_escape(input logic [7:0] b);
        esd_map_t m;
        m.hit = 1'b1;
        case (b)
            CH_A:         m.value = 8'd7;
            CH_B:         m.value = 8'd8;
            CH_F:         m.value = 8'd12;
            CH_N:         m.value = 8'd10;
            CH_R:         m.value = 8'd13;
            CH_T:         m.value = 8'd9;
            CH_V:         m.value = 8'd11;
            CH_QUOTE:     m.value = CH_QUOTE;
            CH_BACKSLASH: m.value = CH_BACKSLASH;
            default:
            begin
                m.hit   = 1'b0;
                m.value = 8'd0;
            end
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/core/esd_front.sv
module esd_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    input  logic                q_full,
    output logic                push,
    output esd_pkg::esd_entry_t push_entry
);

    esd_pkg::esd_mode_t mode_reg;
    esd_pkg::esd_mode_t mode_next;
    logic [6:0]         acc_reg;
    logic [6:0]         acc_next;

    logic               accept;
    logic               digit;
    logic [3:0]         dval;
    logic [9:0]         new_acc;
    esd_pkg::esd_map_t  map;
    logic               is_bs;
    logic               nb_pres;
    logic               e_pres;
    logic [7:0]         e_byte;
    logic               f_pres;
    logic [7:0]         f_byte;
    logic               any;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign digit    = (in_byte >= esd_pkg::CH_ZERO) && (in_byte <= esd_pkg::CH_NINE);
    assign dval     = in_byte[3:0];
    assign new_acc  = {acc_reg, 3'b000} + {6'd0, dval};
    assign map      = esd_pkg::simple_escape(in_byte);
    assign is_bs    = (in_byte == esd_pkg::CH_BACKSLASH);
    assign nb_pres  = !is_bs || in_last;

    // next state
    always_comb
    begin
        mode_next = esd_pkg::MODE_NORMAL;
        acc_next  = 7'd0;
        case (mode_reg)
            esd_pkg::MODE_NORMAL:
            begin
                if (is_bs && !in_last)
                    mode_next = esd_pkg::MODE_ESC;
            end
            esd_pkg::MODE_ESC:
            begin
                if (!map.hit && digit && !in_last)
                begin
                    mode_next = esd_pkg::MODE_OCT1;
                    acc_next  = {3'd0, dval};
                end
            end
            esd_pkg::MODE_OCT1:
            begin
                if (digit && !in_last)
                begin
                    mode_next = esd_pkg::MODE_OCT2;
                    acc_next  = new_acc[6:0];
                end
                else if (!digit && is_bs && !in_last)
                    mode_next = esd_pkg::MODE_ESC;
            end
            esd_pkg::MODE_OCT2:
            begin
                if (!digit && is_bs && !in_last)
                    mode_next = esd_pkg::MODE_ESC;
            end
            default:
            begin
                mode_next = esd_pkg::MODE_NORMAL;
            end
        endcase
    end

    // results of this beat, in order e then f
    always_comb
    begin
        e_pres = 1'b0;
        e_byte = 8'd0;
        f_pres = 1'b0;
        f_byte = in_byte;
        case (mode_reg)
            esd_pkg::MODE_NORMAL:
            begin
                f_pres = nb_pres;
            end
            esd_pkg::MODE_ESC:
            begin
                if (map.hit)
                begin
                    f_pres = 1'b1;
                    f_byte = map.value;
                end
                else if (digit)
                begin
                    f_pres = in_last;
                    f_byte = {4'd0, dval};
                end
                else
                begin
                    e_pres = 1'b1;
                    e_byte = esd_pkg::CH_BACKSLASH;
                    f_pres = 1'b1;
                end
            end
            esd_pkg::MODE_OCT1, esd_pkg::MODE_OCT2:
            begin
                if (digit)
                begin
                    f_pres = ((mode_reg == esd_pkg::MODE_OCT2) || in_last)
                             && (new_acc < esd_pkg::VALUE_LIMIT);
                    f_byte = new_acc[7:0];
                end
                else
                begin
                    e_pres = 1'b1;
                    e_byte = {1'b0, acc_reg};
                    f_pres = nb_pres;
                end
            end
            default:
            begin
                f_pres = 1'b0;
            end
        endcase
    end

    assign any              = e_pres || f_pres;
    assign push             = accept && (any || in_last);
    assign push_entry.byte0 = e_pres ? e_byte : (f_pres ? f_byte : 8'd0);
    assign push_entry.pres0 = any;
    assign push_entry.byte1 = f_byte;
    assign push_entry.two   = e_pres && f_pres;
    assign push_entry.last  = in_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= esd_pkg::MODE_NORMAL;
            acc_reg  <= 7'd0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

FILE: rtl/core/esd_queue.sv
module esd_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  esd_pkg::esd_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output esd_pkg::esd_entry_t pop_entry,
    output logic                empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    esd_pkg::esd_entry_t mem [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                do_push;
    logic                do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_entry = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_ONE;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_ONE;
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_ONE;
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_ONE;
        end
    end

endmodule

FILE: rtl/core/esd_back.sv
module esd_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  esd_pkg::esd_entry_t q_entry,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                out_present,
    output logic                out_last
);

    esd_pkg::esd_entry_t cur_reg;
    logic                cur_valid_reg;
    logic                sub_reg;
    logic                beat_done;
    logic                final_beat;
    logic                load;

    assign beat_done  = cur_valid_reg && out_ready;
    assign final_beat = sub_reg || !cur_reg.two;
    assign load       = !q_empty && (!cur_valid_reg || (beat_done && final_beat));
    assign pop        = load;

    assign out_valid   = cur_valid_reg;
    assign out_byte    = sub_reg ? cur_reg.byte1 : cur_reg.byte0;
    assign out_present = sub_reg || cur_reg.pres0;
    assign out_last    = cur_reg.last && final_beat;

    always_ff @(posedge clk)
    begin
        if (load)
            cur_reg <= q_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            sub_reg       <= 1'b0;
        end
        else if (load)
        begin
            cur_valid_reg <= 1'b1;
            sub_reg       <= 1'b0;
        end
        else if (beat_done)
        begin
            cur_valid_reg <= !final_beat;
            sub_reg       <= !final_beat;
        end
    end

endmodule

FILE: rtl/core/escape_sequence_decoder.sv
// A result passes the queue memory, then the output register. One input
// beat per cycle while the queue is not full; an escape that yields two
// bytes leaves as two beats, one per cycle while m_axis_tready is high.
// A small queue between decode and output absorbs output stalls.
// Reset (rst_n low, asynchronous): decoder returns to normal mode, queue
// empties, no output beat is valid.
module escape_sequence_decoder
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,  // [7:0] out_byte
    output logic [0:0] m_axis_tuser,  // [0] byte_present
    output logic       m_axis_tlast
);

    esd_pkg::esd_entry_t push_entry;
    esd_pkg::esd_entry_t pop_entry;
    logic                push;
    logic                pop;
    logic                q_full;
    logic                q_empty;

    esd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    esd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (q_empty)
    );

    esd_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_entry     (pop_entry),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_byte    (m_axis_tdata),
        .out_present (m_axis_tuser[0]),
        .out_last    (m_axis_tlast)
    );

endmodule

FILE: rtl/core/esd_checker.sv
module esd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [0:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !m_axis_tvalid)
        else $error("output beat valid during reset");

    a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == 8'd0))
        else $error("end marker beat not last or not zero");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (.*);

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       last;
    } res_t;

    // one string byte, with the results typed in where they are obvious
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        logic [1:0] n;
        res_t       r0;
        res_t       r1;
    } row_t;

    localparam res_t NO_RES = '0;
    localparam int   N_DIRECTED = 27;

    localparam row_t DIRECTED [N_DIRECTED] = '{
        '{8'h00,                 1'b1, 1'b1, 2'd1, '{8'h00, 1'b1, 1'b1}, NO_RES},
        '{8'hff,                 1'b0, 1'b1, 2'd1, '{8'hff, 1'b1, 1'b0}, NO_RES},
        '{esd_pkg::CH_BACKSLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{esd_pkg::CH_N,         1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{esd_pkg::CH_BACKSLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'h22,                 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{esd_pkg::CH_BACKSLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'h33,                 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'h37,                 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'h37,                 1'b0, 1'b1, 2'd1, '{8'hff, 1'b1, 1'b0}, NO_RES},
        '{esd_pkg::CH_BACKSLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'h39,                 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'h39,                 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'h39,                 1'b1, 1'b1, 2'd1, '{8'h00, 1'b0, 1'b1}, NO_RES},
        '{esd_pkg::CH_BACKSLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'h31,                 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'h78,                 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{esd_pkg::CH_BACKSLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'h32,                 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{esd_pkg::CH_BACKSLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{esd_pkg::CH_A,         1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{esd_pkg::CH_BACKSLASH, 1'b1, 1'b1, 2'd1,
          '{esd_pkg::CH_BACKSLASH, 1'b1, 1'b1}, NO_RES},
        '{esd_pkg::CH_BACKSLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'h34,                 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'h30,                 1'b1, 1'b0, 2'd0, NO_RES, NO_RES},
        '{esd_pkg::CH_BACKSLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{esd_pkg::CH_QUOTE,     1'b1, 1'b0, 2'd0, NO_RES, NO_RES}
    };

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic [0:0] m_axis_tuser;
    logic       m_axis_tlast;

    esd_pkg::esd_mode_t dec_mode;
    logic [9:0]         oct_acc;
    res_t               beat_results[$];
    res_t               decoded_bytes[$];
    row_t               string_feed[$];
    row_t               cur_row;
    res_t               exp_res;

    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int          rx_hold;
    int          errors;
    int          beats_in;
    int          strings_in;
    int          results_checked;

    escape_sequence_decoder dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic void add_byte(input logic [7:0] b);
        res_t r;
        r.data    = b;
        r.present = 1'b1;
        r.last    = 1'b0;
        beat_results.push_back(r);
    endfunction

    function automatic void plain_byte(input logic [7:0] b, input logic last);
        if (b == esd_pkg::CH_BACKSLASH && !last)
            dec_mode = esd_pkg::MODE_ESC;
        else
            add_byte(b);
    endfunction

    function automatic void flush_octal();
        if (oct_acc < esd_pkg::VALUE_LIMIT)
            add_byte(oct_acc[7:0]);
        oct_acc  = '0;
        dec_mode = esd_pkg::MODE_NORMAL;
    endfunction

    function automatic void decode_beat(input logic [7:0] b, input logic last);
        logic       is_dig;
        logic       hit;
        logic [7:0] ctl;
        res_t       r;
        beat_results.delete();
        is_dig = (b >= esd_pkg::CH_ZERO) && (b <= esd_pkg::CH_NINE);
        hit    = 1'b1;
        ctl    = 8'd0;
        case (b)
            esd_pkg::CH_A:         ctl = 8'd7;
            esd_pkg::CH_B:         ctl = 8'd8;
            esd_pkg::CH_F:         ctl = 8'd12;
            esd_pkg::CH_N:         ctl = 8'd10;
            esd_pkg::CH_R:         ctl = 8'd13;
            esd_pkg::CH_T:         ctl = 8'd9;
            esd_pkg::CH_V:         ctl = 8'd11;
            esd_pkg::CH_QUOTE:     ctl = esd_pkg::CH_QUOTE;
            esd_pkg::CH_BACKSLASH: ctl = esd_pkg::CH_BACKSLASH;
            default:               hit = 1'b0;
        endcase
        case (dec_mode)
            esd_pkg::MODE_NORMAL:
                plain_byte(b, last);
            esd_pkg::MODE_ESC:
            begin
                dec_mode = esd_pkg::MODE_NORMAL;
                if (hit)
                    add_byte(ctl);
                else if (is_dig)
                begin
                    oct_acc  = {2'b00, b - esd_pkg::CH_ZERO};
                    dec_mode = esd_pkg::MODE_OCT1;
                    if (last)
                        flush_octal();
                end
                else
                begin
                    add_byte(esd_pkg::CH_BACKSLASH);
                    add_byte(b);
                end
            end
            default:
            begin
                if (is_dig)
                begin
                    oct_acc = {oct_acc[6:0], 3'b000} + {2'b00, b - esd_pkg::CH_ZERO};
                    if (dec_mode == esd_pkg::MODE_OCT1 && !last)
                        dec_mode = esd_pkg::MODE_OCT2;
                    else
                        flush_octal();
                end
                else
                begin
                    flush_octal();
                    plain_byte(b, last);
                end
            end
        endcase
        if (last)
        begin
            if (beat_results.size() == 0)
                r = '{8'h00, 1'b0, 1'b1};
            else
            begin
                r      = beat_results.pop_back();
                r.last = 1'b1;
            end
            beat_results.push_back(r);
            dec_mode = esd_pkg::MODE_NORMAL;
            oct_acc  = '0;
        end
    endfunction

    // pick segments: plain bytes, simple escapes, digit escapes, stray escapes, lone backslashes
    task automatic queue_strings(input int target);
        logic [7:0]  letters [9];
        logic [7:0]  str[$];
        int          added;
        int          segs;
        int          nd;
        int unsigned kind;
        row_t        row;
        letters = '{esd_pkg::CH_A, esd_pkg::CH_B, esd_pkg::CH_F, esd_pkg::CH_N,
                    esd_pkg::CH_R, esd_pkg::CH_T, esd_pkg::CH_V, esd_pkg::CH_QUOTE,
                    esd_pkg::CH_BACKSLASH};
        added = 0;
        while (added < target)
        begin
            str.delete();
            segs = $urandom_range(1, 6);
            for (int k = 0; k < segs; k++)
            begin
                kind = $urandom_range(99);
                if (kind < 35)
                    str.push_back(8'($urandom_range(255)));
                else if (kind < 60)
                begin
                    str.push_back(esd_pkg::CH_BACKSLASH);
                    str.push_back(letters[$urandom_range(8)]);
                end
                else if (kind < 82)
                begin
                    str.push_back(esd_pkg::CH_BACKSLASH);
                    nd = $urandom_range(1, 3);
                    for (int d = 0; d < nd; d++)
                        str.push_back(esd_pkg::CH_ZERO + 8'($urandom_range(9)));
                end
                else if (kind < 94)
                begin
                    str.push_back(esd_pkg::CH_BACKSLASH);
                    str.push_back(8'($urandom_range(255)));
                end
                else
                    str.push_back(esd_pkg::CH_BACKSLASH);
            end
            for (int k = 0; k < str.size(); k++)
            begin
                row       = '0;
                row.data  = str[k];
                row.last  = (k == str.size() - 1);
                string_feed.push_back(row);
            end
            added += str.size();
        end
    endtask

    task automatic drain();
        while (string_feed.size() != 0 || decoded_bytes.size() != 0)
            @(posedge clk);
    endtask

    // sender: retire the accepted beat, then offer the next or idle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                cur_row = string_feed.pop_front();
                decode_beat(cur_row.data, cur_row.last);
                if (cur_row.typed)
                begin
                    if (cur_row.n > 0)
                        decoded_bytes.push_back(cur_row.r0);
                    if (cur_row.n > 1)
                        decoded_bytes.push_back(cur_row.r1);
                end
                else
                    foreach (beat_results[k])
                        decoded_bytes.push_back(beat_results[k]);
                beats_in++;
                if (cur_row.last)
                    strings_in++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (string_feed.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= string_feed[0].data;
                    s_axis_tlast  <= string_feed[0].last;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: check the beat, then stall at random or for a hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (decoded_bytes.size() == 0)
                begin
                    $display("%0t: unexpected result data=%h present=%b last=%b",
                             $time, m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
                    errors++;
                end
                else
                begin
                    exp_res = decoded_bytes.pop_front();
                    if (m_axis_tdata !== exp_res.data
                        || m_axis_tuser[0] !== exp_res.present
                        || m_axis_tlast !== exp_res.last)
                    begin
                        $display({"%0t: mismatch expected data=%h present=%b last=%b,",
                                  " got data=%h present=%b last=%b"},
                                 $time, exp_res.data, exp_res.present, exp_res.last,
                                 m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
                        errors++;
                    end
                    results_checked++;
                end
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = 8'h00;
        s_axis_tlast    = 1'b0;
        m_axis_tready   = 1'b0;
        dec_mode        = esd_pkg::MODE_NORMAL;
        oct_acc         = '0;
        tx_idle_pct     = 12;
        rx_idle_pct     = 61;
        rx_hold         = 0;
        errors          = 0;
        beats_in        = 0;
        strings_in      = 0;
        results_checked = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            string_feed.push_back(DIRECTED[i]);
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 61 : 0;
            rx_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 12 : 0;
            // hold off the receiver while the sender keeps offering
            if (phase == 2)
                rx_hold = 200;
            queue_strings(530);
            drain();
        end

        repeat (10) @(posedge clk);
        $display("covered %0d beats in %0d strings, %0d results checked", beats_in,
                 strings_in, results_checked);
        $display("escapes: simple, digit runs of one to three, oversized, stray, trailing");
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout");
        $display("tb NOT OK");
        $finish;
    end

endmodule
